### sv/assert_macros.svh
// assertion macros for the rtl modules, included by jct_parse
// no dependencies; the including module must have clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CHECK(lbl, prop)

`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### sv/jct_pkg.sv
// types, codes and the value classifier of the command tokenizer
// no dependencies
package jct_pkg;

    localparam int REG_IDX_W = 2;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int POS_W     = 6;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TERMINAL = 2'd0,
        REG_QUOTE    = 2'd1,
        REG_COLON    = 2'd2,
        REG_CLOSE    = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        EV_IGNORED  = 3'd0,
        EV_CMD_BYTE = 3'd1,
        EV_CMD_DONE = 3'd2,
        EV_VAL_BYTE = 3'd3,
        EV_VAL_DONE = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        KIND_UNDEF  = 3'd0,
        KIND_NULL   = 3'd1,
        KIND_BOOL   = 3'd2,
        KIND_NUMBER = 3'd3,
        KIND_STRING = 3'd4
    } kind_t;

    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_N      = 8'h6e;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_MINUS  = 8'h2d;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [7:0] RST_TERMINAL = 8'd10;
    localparam logic [7:0] RST_QUOTE    = 8'd34;
    localparam logic [7:0] RST_COLON    = 8'd58;
    localparam logic [7:0] RST_CLOSE    = 8'd125;

    typedef struct packed {
        logic [7:0] terminal_char;
        logic [7:0] quote_char;
        logic [7:0] colon_char;
        logic [7:0] close_char;
    } cfg_t;

    typedef struct packed {
        event_t           ev;
        logic [7:0]       chr;
        logic [POS_W-1:0] pos;
        kind_t            kind;
        logic             line_end;
    } res_t;

    function automatic kind_t classify(input logic [7:0] b);
        kind_t k;
        k = KIND_UNDEF;
        if (b == CHAR_N)
        begin
            k = KIND_NULL;
        end
        else if (b == CHAR_T || b == CHAR_F)
        begin
            k = KIND_BOOL;
        end
        else if (b == CHAR_MINUS || (b >= CHAR_ZERO && b <= CHAR_NINE))
        begin
            k = KIND_NUMBER;
        end
        else if (b == CHAR_DQUOTE)
        begin
            k = KIND_STRING;
        end
        return k;
    endfunction

endpackage

### sv/jct_cfg.sv
// apb register file for the delimiter bytes of the command tokenizer
// depends on jct_pkg
module jct_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jct_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output jct_pkg::cfg_t               cfg
);
    import jct_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;
    logic [7:0] rd_byte;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_TERMINAL: cfg_next.terminal_char = pwdata[7:0];
                REG_QUOTE:    cfg_next.quote_char    = pwdata[7:0];
                REG_COLON:    cfg_next.colon_char    = pwdata[7:0];
                REG_CLOSE:    cfg_next.close_char    = pwdata[7:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TERMINAL: rd_byte = cfg_reg.terminal_char;
            REG_QUOTE:    rd_byte = cfg_reg.quote_char;
            REG_COLON:    rd_byte = cfg_reg.colon_char;
            REG_CLOSE:    rd_byte = cfg_reg.close_char;
            default:      rd_byte = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.terminal_char <= RST_TERMINAL;
            cfg_reg.quote_char    <= RST_QUOTE;
            cfg_reg.colon_char    <= RST_COLON;
            cfg_reg.close_char    <= RST_CLOSE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/jct_parse.sv
// parser state and per-byte next-state logic of the command tokenizer
// depends on jct_pkg and assert_macros.svh
`include "assert_macros.svh"

module jct_parse #(
    parameter int LINE_BYTES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     rx_byte,
    input  jct_pkg::cfg_t  cfg,
    output jct_pkg::res_t  res
);
    import jct_pkg::*;

    localparam int LCW = $clog2(LINE_BYTES + 1);

    typedef enum logic [2:0] {
        PH_WAIT_QUOTE = 3'd0,
        PH_CMD        = 3'd1,
        PH_WAIT_COLON = 3'd2,
        PH_VALUE      = 3'd3,
        PH_IGNORE     = 3'd4
    } phase_t;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [POS_W-1:0] field_reg;
    logic [POS_W-1:0] field_next;
    logic [LCW-1:0]   line_reg;
    logic [LCW-1:0]   line_next;
    logic [LCW-1:0]   line_inc;
    kind_t            kind_reg;
    kind_t            kind_next;
    event_t           ev;
    logic [POS_W-1:0] pos;
    logic             lend;
    logic             term_hit;

    assign term_hit = (rx_byte == cfg.terminal_char);

    always_comb
    begin
        phase_next = phase_reg;
        field_next = field_reg;
        line_next  = line_reg;
        kind_next  = kind_reg;
        ev         = EV_IGNORED;
        pos        = '0;
        lend       = 1'b0;
        line_inc   = line_reg + 1'b1;
        if (term_hit)
        begin
            phase_next = PH_WAIT_QUOTE;
            field_next = '0;
            line_next  = '0;
            lend       = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT_QUOTE:
                begin
                    if (rx_byte == cfg.quote_char)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    pos = field_reg;
                    if (rx_byte == cfg.quote_char)
                    begin
                        ev         = EV_CMD_DONE;
                        field_next = '0;
                        phase_next = PH_WAIT_COLON;
                    end
                    else
                    begin
                        ev         = EV_CMD_BYTE;
                        field_next = field_reg + 1'b1;
                    end
                end
                PH_WAIT_COLON:
                begin
                    if (rx_byte == cfg.colon_char)
                    begin
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    pos = field_reg;
                    // type is taken before the close test, so an empty value classifies the brace
                    if (field_reg == '0)
                    begin
                        kind_next = classify(rx_byte);
                    end
                    if (rx_byte == cfg.close_char)
                    begin
                        ev         = EV_VAL_DONE;
                        phase_next = PH_IGNORE;
                    end
                    else
                    begin
                        ev         = EV_VAL_BYTE;
                        field_next = field_reg + 1'b1;
                    end
                end
                default:
                begin
                    ev = EV_IGNORED;
                end
            endcase
            line_next = line_inc;
            if (line_inc == LCW'(LINE_BYTES))
            begin
                phase_next = PH_WAIT_QUOTE;
                field_next = '0;
                line_next  = '0;
                lend       = 1'b1;
            end
        end
        res.ev       = ev;
        res.chr      = rx_byte;
        res.pos      = pos;
        res.kind     = kind_next;
        res.line_end = lend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_QUOTE;
            field_reg <= '0;
            line_reg  <= '0;
            kind_reg  <= KIND_UNDEF;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            field_reg <= field_next;
            line_reg  <= line_next;
            kind_reg  <= kind_next;
        end
    end

    `ASSERT_CHECK(a_line_range, line_reg < LCW'(LINE_BYTES))
    `ASSERT_CHECK(a_terminal_restart, step && term_hit |=> phase_reg == PH_WAIT_QUOTE && line_reg == '0)
    `ASSERT_CHECK(a_end_restart, step && res.line_end |=> phase_reg == PH_WAIT_QUOTE && field_reg == '0)
    `ASSERT_CHECK(a_hold_idle, !step |=> $stable(phase_reg) && $stable(kind_reg) && $stable(line_reg))
    `ASSERT_CHECK(a_field_cleared, phase_reg == PH_WAIT_QUOTE || phase_reg == PH_WAIT_COLON |-> field_reg == '0)

endmodule

### sv/json_command_tokenizer.sv
// json_command_tokenizer: splits one-line {"cmd":value} messages into per-byte events
//
// rx channel: one byte per transfer (rx_valid/rx_ready). res channel: one result
// transfer per byte (event_res, char_out, position, value_kind, line_end).
// a byte is held in an input register, parsed combinationally against the parser
// state and written to the result register while phase, field index, line count
// and type update together; throughput is one byte per cycle while rx_valid and
// res_ready stay high.
// while res_ready is low the result register holds and the input register
// fills; rx_ready then drops until the result is taken, and nothing is lost.
// the delimiter bytes sit in an apb register file (terminal, quote, colon, close at
// byte addresses 0, 4, 8, 12); the user must write them only while idle, unchecked.
// reset (rst_n low, asynchronous) empties both registers, restarts the parser
// in the wait-for-quote phase with an undefined value type and loads the
// default delimiters (line feed, double quote, colon, closing brace).
// LINE_BYTES sets how many parsed bytes end a line without a terminal byte.
// depends on jct_pkg, jct_cfg and jct_parse
module json_command_tokenizer #(
    parameter int LINE_BYTES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jct_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        rx_valid,
    output logic                        rx_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [2:0]                  event_res,
    output logic [7:0]                  char_out,
    output logic [jct_pkg::POS_W-1:0]   position,
    output logic [2:0]                  value_kind,
    output logic                        line_end
);
    import jct_pkg::*;

    cfg_t       cfg;
    res_t       res;
    res_t       res_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       adv;

    // parse when the held byte can move into a free or draining result register
    assign adv      = in_valid_reg && (!out_valid_reg || res_ready);
    assign rx_ready = !in_valid_reg || adv;

    jct_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jct_parse #(
        .LINE_BYTES (LINE_BYTES)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (adv),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_ready)
            begin
                in_valid_reg <= rx_valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (adv)
        begin
            res_reg <= res;
        end
    end

    assign res_valid  = out_valid_reg;
    assign event_res  = res_reg.ev;
    assign char_out   = res_reg.chr;
    assign position   = res_reg.pos;
    assign value_kind = res_reg.kind;
    assign line_end   = res_reg.line_end;

endmodule
